### rtl/ddgtp_pkg.sv
// Package: constants, tables and helper functions for the go-to-point steering pipeline.
package ddgtp_pkg;

  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int SIGMOID_ENTRIES_DEF  = 64;

  localparam int CRUISE_RESET = 180;

  localparam int ATAN_COUNT = 24;
  localparam int ATAN_DEG_Q16 [ATAN_COUNT] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  localparam int ROOT_W = 15;
  localparam int SQ_W   = 30;

  localparam int RECIP_90    = 186414;
  localparam int RECIP_100   = 167773;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 18;

  localparam logic [63:0] SIG_STEP_Q30 = 64'd890163237;
  localparam logic [63:0] ONE_Q30      = 64'd1073741824;
  localparam int          THIRTY_PCT_Q16 = 19661;

  typedef enum logic [1:0] {
    MODE_FWD,
    MODE_REV,
    MODE_SPIN
  } drive_mode_t;

  // Q16 logistic value for integer distance n, evaluated at elaboration
  function automatic logic [16:0] sig_q16(input logic [10:0] n);
    logic [63:0] e;
    logic [63:0] b;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    logic [10:0] k;
    e   = ONE_Q30;
    b   = SIG_STEP_Q30;
    k   = n;
    q   = '0;
    rem = '0;
    for (int i = 0; i < 11; i++) begin
      if (k[0]) begin
        e = (e * b + (ONE_Q30 >> 1)) >> 30;
      end
      b = (b * b + (ONE_Q30 >> 1)) >> 30;
      k = k >> 1;
    end
    den = ONE_Q30 + e;
    num = (64'd1 << 46) + (den >> 1);
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q[16:0];
  endfunction

  // One digit of the restoring square root
  function automatic logic [SQ_W+ROOT_W-1:0] sq_step(input logic [SQ_W-1:0] rem,
                                                      input logic [ROOT_W-1:0] root,
                                                      input int j);
    logic [31:0] t;
    logic [31:0] r32;
    t   = (32'(root) << (j + 1)) + (32'd1 << (2 * j));
    r32 = 32'(rem);
    if (r32 >= t) begin
      return {SQ_W'(r32 - t), root | (ROOT_W'(1) << j)};
    end
    return {rem, root};
  endfunction

endpackage

### rtl/diff_drive_goto_point.sv
// Top level: pipelined go-to-point wheel speed controller for a two-wheel robot.
//
// Input stream (in_*): one pose/target item per transfer. Result stream (out_*):
// one item per input, carrying the left and right wheel speeds in 1/16 units.
// Config channel (cfg_*): writes cruise_speed; ready out of reset; write only while idle.
//
// Throughput: one item per cycle while the output is not stalled. The pipeline depth is
// set mostly by the bearing CORDIC, one iteration per stage, with the square root
// digits taken two per stage alongside it.
// Further stages: squares, distance sum, bearing wrap and sigmoid lookup, speed
// product, gain product, reciprocal divide, wheel sums with saturation.
//
// The whole pipeline advances together whenever the output register is empty or
// being taken; a stalled receiver freezes every stage, nothing is dropped or
// repeated. Synchronous reset clears all valid bits and sets cruise_speed to 180;
// in_tready and cfg_ready stay low while reset is held.
module diff_drive_goto_point
  import ddgtp_pkg::*;
#(
  parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF,
  parameter int SIGMOID_ENTRIES  = SIGMOID_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // robot_x[13:0], robot_y[27:14], robot_heading[41:28], target_x[55:42],
  // target_y[69:56], zero[71:70]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // left_wheel[12:0], right_wheel[25:13], zero[31:26]
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int AI     = ANGLE_ITERATIONS;
  localparam int SIG_AW = (SIGMOID_ENTRIES > 1) ? $clog2(SIGMOID_ENTRIES) : 1;
  localparam logic [SQ_W-1:0] FAR_SQ = SQ_W'(SIGMOID_ENTRIES * SIGMOID_ENTRIES);
  localparam int CW = 26;
  localparam int ZW = 26;

  logic       pipe_en;
  logic [7:0] cruise_r;

  assign cfg_ready = rst_n;
  assign pipe_en   = !out_tvalid || out_tready;
  assign in_tready = pipe_en && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cruise_r <= 8'(CRUISE_RESET);
    end else if (cfg_valid) begin
      cruise_r <= cfg_data;
    end
  end

  // Sigmoid table
  logic [16:0] sig_rom [SIGMOID_ENTRIES];
  for (genvar g = 0; g < SIGMOID_ENTRIES; g++) begin : g_rom
    assign sig_rom[g] = sig_q16(11'(g));
  end

  // Stage P0: offsets
  logic               v0_r;
  logic signed [14:0] dx0_r, dy0_r;
  logic signed [13:0] hd0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (pipe_en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dx0_r <= 15'(signed'(in_tdata[55:42])) - 15'(signed'(in_tdata[13:0]));
      dy0_r <= 15'(signed'(in_tdata[69:56])) - 15'(signed'(in_tdata[27:14]));
      hd0_r <= signed'(in_tdata[41:28]);
    end
  end

  // Stage P1: squares, quadrant pre-rotation
  logic                 v1_r;
  logic [28:0]          sqx1_r, sqy1_r;
  logic signed [CW-1:0] x1_r, y1_r;
  logic signed [ZW-1:0] z1_r;
  logic                 zero1_r;
  logic signed [13:0]   hd1_r;
  logic signed [CW-1:0] xin, yin;

  assign xin = CW'(dx0_r) <<< 8;
  assign yin = CW'(dy0_r) <<< 8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sqx1_r  <= 29'(dx0_r) * 29'(dx0_r);
      sqy1_r  <= 29'(dy0_r) * 29'(dy0_r);
      zero1_r <= (dx0_r == '0) && (dy0_r == '0);
      hd1_r   <= hd0_r;
      if (xin < 0) begin
        if (yin >= 0) begin
          x1_r <= yin;
          y1_r <= -xin;
          z1_r <= ZW'(90 * 65536);
        end else begin
          x1_r <= -yin;
          y1_r <= xin;
          z1_r <= -ZW'(90 * 65536);
        end
      end else begin
        x1_r <= xin;
        y1_r <= yin;
        z1_r <= '0;
      end
    end
  end

  // CORDIC chain; entry 0 also forms the squared distance and its bands
  logic                 cv_r    [AI+1];
  logic signed [CW-1:0] cx_r    [AI+1];
  logic signed [CW-1:0] cy_r    [AI+1];
  logic signed [ZW-1:0] cz_r    [AI+1];
  logic [SQ_W-1:0]      crem_r  [AI+1];
  logic [ROOT_W-1:0]    croot_r [AI+1];
  logic                 czero_r [AI+1];
  logic signed [13:0]   chd_r   [AI+1];
  logic                 cfar_r  [AI+1];
  logic                 cnear_r [AI+1];
  logic [4:0]           ck_r    [AI+1];

  logic [SQ_W-1:0] sq_sum;
  logic [4:0]      k_band;

  assign sq_sum = SQ_W'(sqx1_r) + SQ_W'(sqy1_r);

  always_comb begin
    priority if (sq_sum > SQ_W'(2560000)) k_band = 5'd17;
    else if (sq_sum > SQ_W'(640000))      k_band = 5'd19;
    else if (sq_sum > SQ_W'(230400))      k_band = 5'd21;
    else if (sq_sum > SQ_W'(102400))      k_band = 5'd23;
    else                                  k_band = 5'd25;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (pipe_en) begin
      cv_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      cx_r[0]    <= x1_r;
      cy_r[0]    <= y1_r;
      cz_r[0]    <= z1_r;
      crem_r[0]  <= sq_sum;
      croot_r[0] <= '0;
      czero_r[0] <= zero1_r;
      chd_r[0]   <= hd1_r;
      cfar_r[0]  <= sq_sum >= FAR_SQ;
      cnear_r[0] <= sq_sum < SQ_W'(6400);
      ck_r[0]    <= k_band;
    end
  end

  for (genvar i = 0; i < AI; i++) begin : g_cordic
    logic signed [CW-1:0]     xs, ys;
    logic [SQ_W+ROOT_W-1:0]   s_a, s_b;

    assign xs = cx_r[i] >>> i;
    assign ys = cy_r[i] >>> i;

    if (2 * i <= ROOT_W - 1) begin : g_d0
      assign s_a = sq_step(crem_r[i], croot_r[i], ROOT_W - 1 - 2 * i);
    end else begin : g_p0
      assign s_a = {crem_r[i], croot_r[i]};
    end
    if (2 * i + 1 <= ROOT_W - 1) begin : g_d1
      assign s_b = sq_step(s_a[SQ_W+ROOT_W-1:ROOT_W], s_a[ROOT_W-1:0], ROOT_W - 2 - 2 * i);
    end else begin : g_p1
      assign s_b = s_a;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (pipe_en) begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        if (cy_r[i] > 0) begin
          cx_r[i+1] <= cx_r[i] + ys;
          cy_r[i+1] <= cy_r[i] - xs;
          cz_r[i+1] <= cz_r[i] + ZW'(ATAN_DEG_Q16[i]);
        end else begin
          cx_r[i+1] <= cx_r[i] - ys;
          cy_r[i+1] <= cy_r[i] + xs;
          cz_r[i+1] <= cz_r[i] - ZW'(ATAN_DEG_Q16[i]);
        end
        crem_r[i+1]  <= s_b[SQ_W+ROOT_W-1:ROOT_W];
        croot_r[i+1] <= s_b[ROOT_W-1:0];
        czero_r[i+1] <= czero_r[i];
        chd_r[i+1]   <= chd_r[i];
        cfar_r[i+1]  <= cfar_r[i];
        cnear_r[i+1] <= cnear_r[i];
        ck_r[i+1]    <= ck_r[i];
      end
    end
  end

  // Stage Q1: bearing, wrapped heading error, sigmoid lookup
  logic                 v_q1_r;
  logic signed [12:0]   e_q1_r;
  logic [16:0]          sig_q1_r;
  logic                 near_q1_r;
  logic [4:0]           k_q1_r;
  logic signed [ZW-1:0] z_rnd;
  logic signed [15:0]   bearing;
  logic signed [16:0]   e_raw, e_w1, e_w2;

  always_comb begin
    z_rnd   = cz_r[AI] + ZW'(2048);
    bearing = czero_r[AI] ? 16'sd1440 : 16'(z_rnd >>> 12);
    e_raw   = 17'(bearing) - 17'(chd_r[AI]);
    if (e_raw > 2880)       e_w1 = e_raw - 17'sd5760;
    else if (e_raw < -2880) e_w1 = e_raw + 17'sd5760;
    else                    e_w1 = e_raw;
    if (e_w1 > 2880)        e_w2 = e_w1 - 17'sd5760;
    else if (e_w1 < -2880)  e_w2 = e_w1 + 17'sd5760;
    else                    e_w2 = e_w1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_q1_r <= 1'b0;
    end else if (pipe_en) begin
      v_q1_r <= cv_r[AI];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      e_q1_r    <= 13'(e_w2);
      sig_q1_r  <= cfar_r[AI] ? 17'd65536 : sig_rom[croot_r[AI][SIG_AW-1:0]];
      near_q1_r <= cnear_r[AI];
      k_q1_r    <= ck_r[AI];
    end
  end

  // Stage Q2: speed product, drive mode, error fold and clamp, gain
  logic               v_q2_r;
  logic signed [26:0] prod_q2_r;
  drive_mode_t        mode_q2_r;
  logic signed [11:0] em_q2_r;
  logic [4:0]         k_q2_r;
  drive_mode_t        mode_c;
  logic signed [13:0] e_rev, e_fold, e_clamp, em_c;
  logic [4:0]         k_c;

  always_comb begin
    e_rev  = 14'(e_q1_r) + 14'sd2880;
    e_fold = (e_rev > 2880) ? e_rev - 14'sd5760 : e_rev;
    if (e_fold > 1280)       e_clamp = 14'sd1280;
    else if (e_fold < -1280) e_clamp = -14'sd1280;
    else                     e_clamp = e_fold;
    priority if (e_q1_r > 1520 || e_q1_r < -1520) begin
      mode_c = MODE_REV;
      em_c   = e_clamp;
    end else if (e_q1_r < 1360 && e_q1_r > -1360) begin
      mode_c = MODE_FWD;
      em_c   = 14'(e_q1_r);
    end else begin
      mode_c = MODE_SPIN;
      em_c   = 14'(e_q1_r);
    end
    if (mode_c == MODE_SPIN)                            k_c = 5'd17;
    else if (near_q1_r && em_c < 640 && em_c > -640)    k_c = 5'd9;
    else                                                k_c = k_q1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_q2_r <= 1'b0;
    end else if (pipe_en) begin
      v_q2_r <= v_q1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      prod_q2_r <= 27'(signed'({1'b0, cruise_r}))
                   * (27'(signed'({1'b0, sig_q1_r})) - 27'(THIRTY_PCT_Q16));
      mode_q2_r <= mode_c;
      em_q2_r   <= 12'(em_c);
      k_q2_r    <= k_c;
    end
  end

  // Stage Q3: base speed, gain numerator with rounding half
  logic               v_q3_r;
  logic signed [13:0] base_q3_r;
  logic [15:0]        num_q3_r;
  logic               neg_q3_r;
  drive_mode_t        mode_q3_r;
  logic [10:0]        abs_e;
  logic [15:0]        half_c;
  logic signed [26:0] base_rnd;

  assign abs_e    = em_q2_r[11] ? 11'(-em_q2_r) : 11'(em_q2_r);
  assign half_c   = (mode_q2_r == MODE_SPIN) ? 16'd50 : 16'd45;
  assign base_rnd = (prod_q2_r + 27'sd2048) >>> 12;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_q3_r <= 1'b0;
    end else if (pipe_en) begin
      v_q3_r <= v_q2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      base_q3_r <= 14'(base_rnd);
      num_q3_r  <= 16'(k_q2_r) * 16'(abs_e) + half_c;
      neg_q3_r  <= em_q2_r[11];
      mode_q3_r <= mode_q2_r;
    end
  end

  // Stage Q4: divide by 90 or 100 through a reciprocal product
  logic               v_q4_r;
  logic [33:0]        prod_q4_r;
  logic signed [13:0] base_q4_r;
  logic               neg_q4_r;
  drive_mode_t        mode_q4_r;
  logic [RECIP_W-1:0] recip;

  assign recip = (mode_q3_r == MODE_SPIN) ? RECIP_W'(RECIP_100) : RECIP_W'(RECIP_90);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_q4_r <= 1'b0;
    end else if (pipe_en) begin
      v_q4_r <= v_q3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      prod_q4_r <= 34'(num_q3_r) * 34'(recip);
      base_q4_r <= base_q3_r;
      neg_q4_r  <= neg_q3_r;
      mode_q4_r <= mode_q3_r;
    end
  end

  // Stage Q5: wheel sums, saturation, output register
  logic               out_vld_r;
  logic [12:0]        left_r, right_r;
  logic [9:0]         quo;
  logic signed [10:0] g_c;
  logic signed [13:0] bsel;
  logic signed [14:0] right_sum, left_sum;
  logic [12:0]        right_sat, left_sat;

  always_comb begin
    quo = prod_q4_r[RECIP_SHIFT+9:RECIP_SHIFT];
    g_c = neg_q4_r ? -11'(quo) : 11'(quo);
    unique case (mode_q4_r)
      MODE_FWD: bsel = base_q4_r;
      MODE_REV: bsel = -base_q4_r;
      default:  bsel = '0;
    endcase
    right_sum = 15'(bsel) + 15'(g_c);
    left_sum  = 15'(bsel) - 15'(g_c);
    if (right_sum > 4095)       right_sat = 13'h0FFF;
    else if (right_sum < -4096) right_sat = 13'h1000;
    else                        right_sat = right_sum[12:0];
    if (left_sum > 4095)        left_sat = 13'h0FFF;
    else if (left_sum < -4096)  left_sat = 13'h1000;
    else                        left_sat = left_sum[12:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pipe_en) begin
      out_vld_r <= v_q4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      left_r  <= left_sat;
      right_r <= right_sat;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, right_r, left_r};

  // Assertions
  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_q1_r |-> (e_q1_r <= 2880 && e_q1_r >= -2880))
    else $error("heading error outside wrap range");

  a_rev_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (v_q2_r && mode_q2_r == MODE_REV) |-> (em_q2_r <= 1280 && em_q2_r >= -1280))
    else $error("reverse error not clamped");

  a_spin_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (v_q2_r && mode_q2_r == MODE_SPIN) |-> (k_q2_r == 5'd17))
    else $error("spin gain wrong");

  a_far_root: assert property (@(posedge clk) disable iff (!rst_n)
    (cv_r[AI] && !cfar_r[AI]) |-> (32'(croot_r[AI]) < 32'(SIGMOID_ENTRIES)))
    else $error("root beyond sigmoid table");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> ($stable(v_q4_r) && $stable(cv_r[0])))
    else $error("pipeline moved during stall");

endmodule
